// ===== src/thfp_pkg.sv =====
// Shared types and constants for the TCP header frame parser.
`timescale 1ns / 1ps

package thfp_pkg;

  // Default width of the saturating byte counter
  localparam int COUNT_BITS_DEF = 16;

  localparam logic [15:0] ETYPE_IPV4    = 16'h0800;
  localparam logic [15:0] ETYPE_IPV6    = 16'h86dd;
  localparam logic [15:0] FRAG_OFS_MASK = 16'h1fff;
  localparam logic [7:0]  PROTO_TCP     = 8'd6;
  localparam logic [3:0]  IP_VER4       = 4'd4;
  localparam logic [3:0]  IP_VER6       = 4'd6;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_SHORT   = 2'd1,
    ST_NOMATCH = 2'd2
  } status_t;

  // One parsed header result
  typedef struct packed {
    status_t     status;
    logic        is_ipv6;
    logic [63:0] src_addr_hi;
    logic [63:0] src_addr_lo;
    logic [63:0] dst_addr_hi;
    logic [63:0] dst_addr_lo;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [31:0] seq_number;
    logic [31:0] ack_number;
    logic        rst_flag;
    logic [15:0] window_size;
  } result_t;

endpackage

// ===== src/thfp_if.sv =====
// Valid/ready channel interfaces for frame bytes and header results.
`timescale 1ns / 1ps

interface thfp_frame_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_end;

  modport source (output valid, data_byte, frame_end, input ready);
  modport sink   (input valid, data_byte, frame_end, output ready);
endinterface

interface thfp_header_if;
  import thfp_pkg::*;

  logic        valid;
  logic        ready;
  status_t     status;
  logic        is_ipv6;
  logic [63:0] src_addr_hi;
  logic [63:0] src_addr_lo;
  logic [63:0] dst_addr_hi;
  logic [63:0] dst_addr_lo;
  logic [15:0] source_port;
  logic [15:0] dest_port;
  logic [31:0] seq_number;
  logic [31:0] ack_number;
  logic        rst_flag;
  logic [15:0] window_size;

  modport source (output valid, status, is_ipv6, src_addr_hi, src_addr_lo, dst_addr_hi,
                  dst_addr_lo, source_port, dest_port, seq_number, ack_number, rst_flag,
                  window_size, input ready);
  modport sink   (input valid, status, is_ipv6, src_addr_hi, src_addr_lo, dst_addr_hi,
                  dst_addr_lo, source_port, dest_port, seq_number, ack_number, rst_flag,
                  window_size, output ready);
endinterface

// ===== src/tcp_header_frame_parser_top.sv =====
// Top level of the Ethernet IPv4/IPv6 TCP header parser.
// The parser takes one frame byte per clock on the frame channel and gives one
// header result per frame on the header channel; the result is registered from
// the beat that carries the last byte. Each byte is matched against fixed header
// offsets as it arrives and captured into holding registers; the final beat is
// judged in the same cycle, so a new frame may follow with no gap. Results pass
// through a two-entry output buffer, so the frame channel keeps taking beats
// while one result waits; it stalls only when both entries are full. The byte
// counter saturates at 2^COUNT_BITS - 1, and no byte past that point is captured.
`timescale 1ns / 1ps

module tcp_header_frame_parser_top #(
  parameter int COUNT_BITS = thfp_pkg::COUNT_BITS_DEF
) (
  input logic           clk,
  input logic           rst,
  thfp_frame_if.sink    frame,
  thfp_header_if.source header
);
  import thfp_pkg::*;

  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  // Capture state
  logic [COUNT_BITS-1:0] byte_count;
  logic [15:0]           frame_type;
  logic [7:0]            version_ihl;
  logic [15:0]           frag_field;
  logic [7:0]            next_proto;
  logic [63:0]           src_hi, src_lo, dst_hi, dst_lo;
  logic [31:0]           port_pair;
  logic [63:0]           seq_ack;
  logic [7:0]            tcp_flags;
  logic [15:0]           window_reg;

  logic [COUNT_BITS-1:0] byte_count_next;
  logic [15:0]           frame_type_next;
  logic [7:0]            version_ihl_next;
  logic [15:0]           frag_field_next;
  logic [7:0]            next_proto_next;
  logic [63:0]           src_hi_next, src_lo_next, dst_hi_next, dst_lo_next;
  logic [31:0]           port_pair_next;
  logic [63:0]           seq_ack_next;
  logic [7:0]            tcp_flags_next;
  logic [15:0]           window_reg_next;

  // Output buffer
  result_t main_res, skid_res, res;
  logic    main_valid, skid_valid;

  logic accept, push, pop;

  assign frame.ready = !skid_valid;
  assign accept      = frame.valid && frame.ready;
  assign push        = accept && frame.frame_end;
  assign pop         = main_valid && header.ready;

  // Match the current byte offset against the header layout
  always_comb begin
    logic                  cap;
    logic [COUNT_BITS-1:0] idx;
    logic [COUNT_BITS-1:0] base;
    logic [COUNT_BITS-1:0] rel;
    logic [7:0]            b;
    logic                  v6;

    b   = frame.data_byte;
    idx = byte_count;
    cap = (byte_count != CNT_MAX);

    frame_type_next  = frame_type;
    version_ihl_next = version_ihl;
    frag_field_next  = frag_field;
    next_proto_next  = next_proto;
    src_hi_next      = src_hi;
    src_lo_next      = src_lo;
    dst_hi_next      = dst_hi;
    dst_lo_next      = dst_lo;
    port_pair_next   = port_pair;
    seq_ack_next     = seq_ack;
    tcp_flags_next   = tcp_flags;
    window_reg_next  = window_reg;
    byte_count_next  = cap ? byte_count + COUNT_BITS'(1) : byte_count;

    if (cap && (idx == COUNT_BITS'(12) || idx == COUNT_BITS'(13))) begin
      frame_type_next = {frame_type[7:0], b};
    end
    v6 = (frame_type_next == ETYPE_IPV6);

    if (cap && idx == COUNT_BITS'(14)) begin
      version_ihl_next = b;
    end

    if (v6) begin
      if (cap && idx == COUNT_BITS'(20)) begin
        next_proto_next = b;
      end
      if (cap && idx >= COUNT_BITS'(22) && idx < COUNT_BITS'(30)) begin
        src_hi_next = {src_hi[55:0], b};
      end
      if (cap && idx >= COUNT_BITS'(30) && idx < COUNT_BITS'(38)) begin
        src_lo_next = {src_lo[55:0], b};
      end
      if (cap && idx >= COUNT_BITS'(38) && idx < COUNT_BITS'(46)) begin
        dst_hi_next = {dst_hi[55:0], b};
      end
      if (cap && idx >= COUNT_BITS'(46) && idx < COUNT_BITS'(54)) begin
        dst_lo_next = {dst_lo[55:0], b};
      end
      base = COUNT_BITS'(54);
    end else begin
      if (cap && (idx == COUNT_BITS'(20) || idx == COUNT_BITS'(21))) begin
        frag_field_next = {frag_field[7:0], b};
      end
      if (cap && idx == COUNT_BITS'(23)) begin
        next_proto_next = b;
      end
      if (cap && idx >= COUNT_BITS'(26) && idx < COUNT_BITS'(30)) begin
        src_lo_next = {src_lo[55:0], b};
      end
      if (cap && idx >= COUNT_BITS'(30) && idx < COUNT_BITS'(34)) begin
        dst_lo_next = {dst_lo[55:0], b};
      end
      base = COUNT_BITS'(14) + COUNT_BITS'({version_ihl_next[3:0], 2'b00});
    end

    // TCP header fields relative to the start of the TCP header
    rel = idx - base;
    if (cap && idx >= base) begin
      priority if (rel < COUNT_BITS'(4)) begin
        port_pair_next = {port_pair[23:0], b};
      end else if (rel < COUNT_BITS'(12)) begin
        seq_ack_next = {seq_ack[55:0], b};
      end else if (rel == COUNT_BITS'(13)) begin
        tcp_flags_next = b;
      end else if (rel == COUNT_BITS'(14) || rel == COUNT_BITS'(15)) begin
        window_reg_next = {window_reg[7:0], b};
      end else begin
        // Data offset byte and everything past the window: hold
        window_reg_next = window_reg;
      end
    end
  end

  // Judge the frame from the state it will hold after this beat
  always_comb begin
    status_t               st;
    logic                  v6ok;
    logic [COUNT_BITS-1:0] v4_need;

    v4_need = COUNT_BITS'(30) + COUNT_BITS'({version_ihl_next[3:0], 2'b00});
    v6ok    = 1'b0;
    priority if (byte_count_next < COUNT_BITS'(14)) begin
      st = ST_SHORT;
    end else if (frame_type_next == ETYPE_IPV4) begin
      priority if (byte_count_next < COUNT_BITS'(34)) begin
        st = ST_SHORT;
      end else if (version_ihl_next[7:4] != IP_VER4) begin
        st = ST_NOMATCH;
      end else if ((frag_field_next & FRAG_OFS_MASK) != 16'd0) begin
        st = ST_NOMATCH;
      end else if (next_proto_next != PROTO_TCP) begin
        st = ST_NOMATCH;
      end else if (byte_count_next < v4_need) begin
        st = ST_SHORT;
      end else begin
        st = ST_OK;
      end
    end else if (frame_type_next == ETYPE_IPV6) begin
      priority if (byte_count_next < COUNT_BITS'(70)) begin
        st = ST_SHORT;
      end else if (version_ihl_next[7:4] != IP_VER6) begin
        st = ST_NOMATCH;
      end else if (next_proto_next != PROTO_TCP) begin
        st = ST_NOMATCH;
      end else begin
        st   = ST_OK;
        v6ok = 1'b1;
      end
    end else begin
      st = ST_NOMATCH;
    end

    res        = '0;
    res.status = st;
    if (st == ST_OK) begin
      res.is_ipv6     = v6ok;
      res.src_addr_hi = v6ok ? src_hi_next : 64'd0;
      res.src_addr_lo = v6ok ? src_lo_next : {32'd0, src_lo_next[31:0]};
      res.dst_addr_hi = v6ok ? dst_hi_next : 64'd0;
      res.dst_addr_lo = v6ok ? dst_lo_next : {32'd0, dst_lo_next[31:0]};
      res.source_port = port_pair_next[31:16];
      res.dest_port   = port_pair_next[15:0];
      res.seq_number  = seq_ack_next[63:32];
      res.ack_number  = seq_ack_next[31:0];
      res.rst_flag    = tcp_flags_next[2];
      res.window_size = window_reg_next;
    end
  end

  // Advance capture state; clear it after the last beat of a frame
  always_ff @(posedge clk) begin
    if (rst || push) begin
      byte_count  <= '0;
      frame_type  <= '0;
      version_ihl <= '0;
      frag_field  <= '0;
      next_proto  <= '0;
      src_hi      <= '0;
      src_lo      <= '0;
      dst_hi      <= '0;
      dst_lo      <= '0;
      port_pair   <= '0;
      seq_ack     <= '0;
      tcp_flags   <= '0;
      window_reg  <= '0;
    end else if (accept) begin
      byte_count  <= byte_count_next;
      frame_type  <= frame_type_next;
      version_ihl <= version_ihl_next;
      frag_field  <= frag_field_next;
      next_proto  <= next_proto_next;
      src_hi      <= src_hi_next;
      src_lo      <= src_lo_next;
      dst_hi      <= dst_hi_next;
      dst_lo      <= dst_lo_next;
      port_pair   <= port_pair_next;
      seq_ack     <= seq_ack_next;
      tcp_flags   <= tcp_flags_next;
      window_reg  <= window_reg_next;
    end
  end

  // Two-entry output buffer: main register in front, skid entry behind
  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        main_res   <= skid_res;
        skid_valid <= 1'b0;
      end else if (push) begin
        main_res <= res;
      end else begin
        main_valid <= 1'b0;
      end
    end else if (push) begin
      if (!main_valid) begin
        main_res   <= res;
        main_valid <= 1'b1;
      end else begin
        skid_res   <= res;
        skid_valid <= 1'b1;
      end
    end
  end

  // Drive the header channel from the front entry
  assign header.valid       = main_valid;
  assign header.status      = main_res.status;
  assign header.is_ipv6     = main_res.is_ipv6;
  assign header.src_addr_hi = main_res.src_addr_hi;
  assign header.src_addr_lo = main_res.src_addr_lo;
  assign header.dst_addr_hi = main_res.dst_addr_hi;
  assign header.dst_addr_lo = main_res.dst_addr_lo;
  assign header.source_port = main_res.source_port;
  assign header.dest_port   = main_res.dest_port;
  assign header.seq_number  = main_res.seq_number;
  assign header.ack_number  = main_res.ack_number;
  assign header.rst_flag    = main_res.rst_flag;
  assign header.window_size = main_res.window_size;

endmodule
